@@ src/midi_note_recorder_player_core_assert.svh @@
// ----------------------------------------------------------------------------
// MIDI note recorder/player assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_RECORDER_PLAYER_CORE_ASSERT_SVH
`define MIDI_NOTE_RECORDER_PLAYER_CORE_ASSERT_SVH

// same-cycle implication
`define MNRP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mnrp assertion failed");

// next-cycle implication
`define MNRP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mnrp assertion failed");

`endif

@@ src/mnrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mnrp_pkg
// Types, codes and the pitch table of the MIDI note recorder/player.
// ----------------------------------------------------------------------------
`default_nettype none

package mnrp_pkg;

  localparam int NOTE_SLOTS = 128;
  localparam int NOTE_W     = 7;
  localparam int START_W    = 16;
  localparam int DUR_W      = 8;
  localparam int FREQ_W     = 12;
  localparam int FREQ_LEN   = 49;

  localparam logic       CMD_MIDI      = 1'b0;
  localparam logic       CMD_TICK      = 1'b1;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [6:0] REPLAY_KEY    = 7'd48;
  localparam logic [6:0] ZERO_NOTE     = 7'd50;
  localparam logic [8:0] OCTAVE        = 9'd12;
  localparam logic [8:0] FREQ_BASE     = 9'd48;
  localparam logic [8:0] FREQ_TOP      = 9'd96;

  localparam logic [FREQ_W-1:0] FREQ_TABLE [FREQ_LEN] = '{
    12'd131,  12'd139,  12'd147,  12'd156,  12'd165,  12'd175,  12'd185,
    12'd196,  12'd208,  12'd220,  12'd233,  12'd247,  12'd262,  12'd277,
    12'd294,  12'd311,  12'd330,  12'd349,  12'd370,  12'd392,  12'd415,
    12'd440,  12'd466,  12'd494,  12'd523,  12'd554,  12'd587,  12'd622,
    12'd659,  12'd698,  12'd740,  12'd784,  12'd831,  12'd880,  12'd932,
    12'd988,  12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
    12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976, 12'd2093
  };

  typedef struct packed {
    logic       cmd;
    logic [7:0] status_byte;
    logic [6:0] note_number;
    logic [6:0] velocity;
  } in_t;

  typedef struct packed {
    logic [11:0] tone_freq;
    logic        playing;
    logic        recorded;
    logic [8:0]  note_count;
  } out_t;

  typedef struct packed {
    logic [DUR_W-1:0]   dur;
    logic [START_W-1:0] start;
    logic [NOTE_W-1:0]  note;
  } mel_entry_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        lt;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_MIDI,
    S_PB_CHK,
    S_PB_START,
    S_PB_SUM,
    S_PB_END,
    S_DONE
  } state_t;

  function automatic logic [FREQ_W-1:0] freq_of(input logic [8:0] idx);
    logic [8:0] off;
    off = idx - FREQ_BASE;
    if (idx >= FREQ_BASE && idx <= FREQ_TOP) begin
      return FREQ_TABLE[off[5:0]];
    end
    return '0;
  endfunction

endpackage

`default_nettype wire

@@ src/mnrp_ram.sv @@
// ----------------------------------------------------------------------------
// mnrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mnrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ src/mnrp_alu.sv @@
// ----------------------------------------------------------------------------
// mnrp_alu
// Shared 32-bit add/subtract unit with unsigned less-than flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mnrp_alu (
  input  wire mnrp_pkg::alu_req_t req,
  output mnrp_pkg::alu_rsp_t      rsp
);

  logic [32:0] diff;
  logic [32:0] sum;

  assign diff = {1'b0, req.a} - {1'b0, req.b};
  assign sum  = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    unique case (req.op)
      mnrp_pkg::ALU_ADD: begin
        rsp.res = sum[31:0];
        rsp.lt  = 1'b0;
      end
      mnrp_pkg::ALU_SUB: begin
        rsp.res = diff[31:0];
        rsp.lt  = diff[32];
      end
      default: begin
        rsp.res = '0;
        rsp.lt  = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/midi_note_recorder_player_core.sv @@
// ----------------------------------------------------------------------------
// midi_note_recorder_player_core
// Records MIDI notes into a melody store and plays them back on 10 ms ticks.
// ----------------------------------------------------------------------------
// An item (MIDI message or tick) is taken when start is high and busy low;
// busy then stays high until its single result is presented on out_data for
// one cycle with out_strobe, which the receiver cannot stall. A MIDI message
// or an idle tick passes through its own state before the done state, a MIDI
// message during playback goes straight to it. Note-on 48 and ticks during
// playback walk the melody store through check, start, sum and end states per
// entry until an entry or the end of store stops it, bounded by the store
// depth. All steps use one shared 32-bit adder/comparator stepped by the
// sequencer and the registered read of the melody and start-tick RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_recorder_player_core #(
  parameter int MELODY_DEPTH = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire mnrp_pkg::in_t   in_data,
  output logic                 out_strobe,
  output mnrp_pkg::out_t       out_data,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_wdata
);

  localparam int AW = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;
  localparam int CW = $clog2(MELODY_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(MELODY_DEPTH);

  mnrp_pkg::state_t   state_r, state_nxt;
  mnrp_pkg::in_t      item_r, item_nxt;
  mnrp_pkg::out_t     out_data_r;
  mnrp_pkg::alu_req_t alu_req;
  mnrp_pkg::alu_rsp_t alu_rsp;
  mnrp_pkg::mel_entry_t mel_rdata, mel_wdata;

  logic [31:0]                     tick_r, tick_nxt;
  logic [6:0]                      cur_note_r, cur_note_nxt;
  logic [mnrp_pkg::NOTE_SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]                   entry_cnt_r, entry_cnt_nxt;
  logic [CW-1:0]                   pidx_r, pidx_nxt;
  logic                            play_r, play_nxt;
  logic [11:0]                     tone_r, tone_nxt;
  logic [7:0]                      shift_r;
  logic                            rec_r, rec_nxt;
  logic                            out_strobe_r;
  logic [15:0]                     end_r, end_nxt;

  logic [6:0]  st_raddr;
  logic [15:0] st_rdata;
  logic [15:0] st_val;
  logic        st_we;
  logic        mel_we;
  logic [3:0]  nib;
  logic        accept;

  assign accept = start && (state_r == mnrp_pkg::S_IDLE);
  assign nib    = item_r.status_byte[7:4];
  assign st_raddr = (state_r == mnrp_pkg::S_IDLE) ? in_data.note_number
                                                  : item_r.note_number;
  assign st_val = valid_r[item_r.note_number] ? st_rdata : 16'd0;

  mnrp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  mnrp_ram #(
    .WIDTH (mnrp_pkg::START_W),
    .DEPTH (mnrp_pkg::NOTE_SLOTS)
  ) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (item_r.note_number),
    .wdata (tick_r[15:0]),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mnrp_ram #(
    .WIDTH ($bits(mnrp_pkg::mel_entry_t)),
    .DEPTH (MELODY_DEPTH)
  ) u_mel_ram (
    .clk   (clk),
    .we    (mel_we),
    .waddr (entry_cnt_r[AW-1:0]),
    .wdata (mel_wdata),
    .raddr (pidx_r[AW-1:0]),
    .rdata (mel_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mnrp_pkg::S_IDLE;
      tick_r       <= '0;
      cur_note_r   <= '0;
      valid_r      <= '0;
      entry_cnt_r  <= '0;
      pidx_r       <= '0;
      play_r       <= 1'b0;
      tone_r       <= '0;
      shift_r      <= 8'd3;
      rec_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      cur_note_r   <= cur_note_nxt;
      valid_r      <= valid_nxt;
      entry_cnt_r  <= entry_cnt_nxt;
      pidx_r       <= pidx_nxt;
      play_r       <= play_nxt;
      tone_r       <= tone_nxt;
      rec_r        <= rec_nxt;
      out_strobe_r <= (state_r == mnrp_pkg::S_DONE);
      if (cfg_we) begin
        shift_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    end_r  <= end_nxt;
    out_data_r.tone_freq  <= tone_r;
    out_data_r.playing    <= play_r;
    out_data_r.recorded   <= rec_r;
    out_data_r.note_count <= 9'(entry_cnt_r);
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    end_nxt       = end_r;
    tick_nxt      = tick_r;
    cur_note_nxt  = cur_note_r;
    valid_nxt     = valid_r;
    entry_cnt_nxt = entry_cnt_r;
    pidx_nxt      = pidx_r;
    play_nxt      = play_r;
    tone_nxt      = tone_r;
    rec_nxt       = rec_r;
    st_we         = 1'b0;
    mel_we        = 1'b0;
    mel_wdata.note  = item_r.note_number;
    mel_wdata.start = st_val;
    mel_wdata.dur   = alu_rsp.res[7:0];
    alu_req.op    = mnrp_pkg::ALU_ADD;
    alu_req.a     = tick_r;
    alu_req.b     = 32'd1;

    unique case (state_r)
      mnrp_pkg::S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          rec_nxt  = 1'b0;
          if (in_data.cmd == mnrp_pkg::CMD_TICK) begin
            state_nxt = mnrp_pkg::S_TICK;
          end else if (play_r) begin
            state_nxt = mnrp_pkg::S_DONE;
          end else begin
            state_nxt = mnrp_pkg::S_MIDI;
          end
        end
      end

      mnrp_pkg::S_TICK: begin
        tick_nxt  = alu_rsp.res;
        state_nxt = play_r ? mnrp_pkg::S_PB_CHK : mnrp_pkg::S_DONE;
      end

      mnrp_pkg::S_MIDI: begin
        // duration = low16(tick) - start, low 8 bits kept
        alu_req.op = mnrp_pkg::ALU_SUB;
        alu_req.a  = {16'd0, tick_r[15:0]};
        alu_req.b  = {16'd0, st_val};
        state_nxt  = mnrp_pkg::S_DONE;
        if (nib == mnrp_pkg::MIDI_NOTE_ON && item_r.velocity != 7'd0) begin
          cur_note_nxt = item_r.note_number;
          if (item_r.note_number == mnrp_pkg::REPLAY_KEY) begin
            tick_nxt  = '0;
            pidx_nxt  = '0;
            play_nxt  = 1'b1;
            state_nxt = mnrp_pkg::S_PB_CHK;
          end else if (item_r.note_number == mnrp_pkg::ZERO_NOTE) begin
            tick_nxt = '0;
          end else begin
            st_we = 1'b1;
            valid_nxt[item_r.note_number] = 1'b1;
            tone_nxt = mnrp_pkg::freq_of(9'(item_r.note_number) + mnrp_pkg::OCTAVE
                                         + 9'(shift_r));
          end
        end else if (nib == mnrp_pkg::MIDI_NOTE_OFF || nib == mnrp_pkg::MIDI_NOTE_ON) begin
          if (cur_note_r == item_r.note_number) begin
            tone_nxt = '0;
          end
          if (st_val != 16'd0 && item_r.note_number != mnrp_pkg::REPLAY_KEY &&
              item_r.note_number != mnrp_pkg::ZERO_NOTE) begin
            if (entry_cnt_r < DEPTH_C) begin
              mel_we        = 1'b1;
              entry_cnt_nxt = entry_cnt_r + CW'(1);
              rec_nxt       = 1'b1;
            end
            valid_nxt[item_r.note_number] = 1'b0;
          end
        end
      end

      mnrp_pkg::S_PB_CHK: begin
        // melody read of pidx issued in this cycle
        if (pidx_r < entry_cnt_r) begin
          state_nxt = mnrp_pkg::S_PB_START;
        end else begin
          play_nxt      = 1'b0;
          tone_nxt      = '0;
          entry_cnt_nxt = '0;
          pidx_nxt      = '0;
          state_nxt     = mnrp_pkg::S_DONE;
        end
      end

      mnrp_pkg::S_PB_START: begin
        alu_req.op = mnrp_pkg::ALU_SUB;
        alu_req.a  = tick_r;
        alu_req.b  = {16'd0, mel_rdata.start};
        if (alu_rsp.lt) begin
          tone_nxt  = '0;
          state_nxt = mnrp_pkg::S_DONE;
        end else begin
          state_nxt = mnrp_pkg::S_PB_SUM;
        end
      end

      mnrp_pkg::S_PB_SUM: begin
        alu_req.op = mnrp_pkg::ALU_ADD;
        alu_req.a  = {16'd0, mel_rdata.start};
        alu_req.b  = {24'd0, mel_rdata.dur};
        end_nxt    = alu_rsp.res[15:0];
        state_nxt  = mnrp_pkg::S_PB_END;
      end

      mnrp_pkg::S_PB_END: begin
        alu_req.op = mnrp_pkg::ALU_SUB;
        alu_req.a  = tick_r;
        alu_req.b  = {16'd0, end_r};
        if (alu_rsp.lt) begin
          tone_nxt  = mnrp_pkg::freq_of(9'(mel_rdata.note) + mnrp_pkg::OCTAVE
                                        + 9'(shift_r));
          state_nxt = mnrp_pkg::S_DONE;
        end else begin
          tone_nxt  = '0;
          pidx_nxt  = pidx_r + CW'(1);
          state_nxt = mnrp_pkg::S_PB_CHK;
        end
      end

      mnrp_pkg::S_DONE: begin
        state_nxt = mnrp_pkg::S_IDLE;
      end

      default: begin
        state_nxt = mnrp_pkg::S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != mnrp_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

`default_nettype wire

@@ src/mnrp_checker.sv @@
// ----------------------------------------------------------------------------
// mnrp_checker
// Port-level checks of the recorder/player, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_note_recorder_player_core_assert.svh"

module mnrp_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           out_strobe,
  input wire mnrp_pkg::out_t out_data
);

  `MNRP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `MNRP_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)
  `MNRP_ASSERT_NOW(a_strobe_idle, out_strobe, !busy)
  `MNRP_ASSERT_NOW(a_no_rec_in_play, out_strobe && out_data.playing, !out_data.recorded)

endmodule

bind midi_note_recorder_player_core mnrp_checker u_mnrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire

@@ verif/tb_midi_note_recorder_player_core.sv @@
// ----------------------------------------------------------------------------
// tb_midi_note_recorder_player_core
// Sends MIDI messages and 10 ms ticks to the recorder/player under random
// idling. Every status result is predicted by a local note recorder model and
// compared field by field. The pitch shift moves through several values,
// including the lowest and the highest. The run covers recording, a full
// melody store and playback.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_midi_note_recorder_player_core;

  localparam int DEPTH       = 256;
  localparam int CHK         = 0;
  localparam int PLAN        = 1;
  localparam int STALL_LIMIT = 20000;
  localparam int SHIFT_RESET = 3;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           start     = 1'b0;
  logic           busy;
  mnrp_pkg::in_t  in_data   = '0;
  logic           out_strobe;
  mnrp_pkg::out_t out_data;
  logic           cfg_we    = 1'b0;
  logic [7:0]     cfg_wdata = '0;

  // two copies of the recorder state: CHK follows accepted transfers,
  // PLAN follows generation so that stimulus can react to the state
  logic [31:0]          tick_r    [2];
  logic [6:0]           last_key  [2];
  logic [15:0]          onset     [2][mnrp_pkg::NOTE_SLOTS];
  mnrp_pkg::mel_entry_t melody    [2][DEPTH];
  logic [8:0]           n_entries [2];
  logic                 playing_r [2];
  logic [8:0]           play_pos  [2];
  logic [11:0]          tone_r    [2];
  logic [7:0]           shift_r   [2];

  mnrp_pkg::in_t  msg_q[$];
  mnrp_pkg::out_t status_due[$];

  int   issued_cnt    = 0;
  int   done_cnt      = 0;
  int   effective_cnt = 0;
  int   recorded_cnt  = 0;
  int   play_cnt      = 0;
  int   shift_cnt     = 0;
  int   fail_cnt      = 0;
  int   idle_left     = 0;
  int   stall_cycles  = 0;
  logic no_idle       = 1'b0;

  midi_note_recorder_player_core #(
    .MELODY_DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void model_clear(int m);
    tick_r[m]    = '0;
    last_key[m]  = '0;
    n_entries[m] = '0;
    playing_r[m] = 1'b0;
    play_pos[m]  = '0;
    tone_r[m]    = '0;
    shift_r[m]   = 8'(SHIFT_RESET);
    for (int n = 0; n < mnrp_pkg::NOTE_SLOTS; n++) onset[m][n] = '0;
    for (int i = 0; i < DEPTH; i++) melody[m][i] = '0;
  endfunction

  function automatic logic [mnrp_pkg::FREQ_W-1:0] pitch_hz(int m, logic [6:0] key);
    int k;
    k = int'(key) + int'(mnrp_pkg::OCTAVE) + int'(shift_r[m]);
    if (k < int'(mnrp_pkg::FREQ_BASE) || k > int'(mnrp_pkg::FREQ_TOP)) return '0;
    return mnrp_pkg::FREQ_TABLE[k - int'(mnrp_pkg::FREQ_BASE)];
  endfunction

  function automatic void walk_melody(int m);
    mnrp_pkg::mel_entry_t e;
    logic [15:0]          stop;
    while (play_pos[m] < n_entries[m]) begin
      e    = melody[m][play_pos[m]];
      stop = e.start + {8'd0, e.dur};
      if (tick_r[m] < {16'd0, e.start}) begin
        tone_r[m] = '0;
        return;
      end
      if (tick_r[m] < {16'd0, stop}) begin
        tone_r[m] = pitch_hz(m, e.note);
        return;
      end
      tone_r[m]   = '0;
      play_pos[m] = play_pos[m] + 9'd1;
    end
    playing_r[m] = 1'b0;
    tone_r[m]    = '0;
    n_entries[m] = '0;
    play_pos[m]  = '0;
  endfunction

  function automatic mnrp_pkg::out_t recorder_step(int m, mnrp_pkg::in_t it);
    mnrp_pkg::out_t       r;
    logic [3:0]           kind;
    logic [6:0]           key;
    logic [15:0]          onset_tick;
    mnrp_pkg::mel_entry_t e;
    logic                 rec;
    kind = it.status_byte[7:4];
    key  = it.note_number;
    rec  = 1'b0;
    if (it.cmd == mnrp_pkg::CMD_TICK) begin
      tick_r[m] = tick_r[m] + 32'd1;
      if (playing_r[m]) walk_melody(m);
    end else if (!playing_r[m]) begin
      if (kind == mnrp_pkg::MIDI_NOTE_ON && it.velocity != 7'd0) begin
        last_key[m] = key;
        if (key == mnrp_pkg::REPLAY_KEY) begin
          tick_r[m]    = '0;
          play_pos[m]  = '0;
          playing_r[m] = 1'b1;
          walk_melody(m);
        end else if (key == mnrp_pkg::ZERO_NOTE) begin
          tick_r[m] = '0;
        end else begin
          onset[m][key] = tick_r[m][15:0];
          tone_r[m]     = pitch_hz(m, key);
        end
      end else if (kind == mnrp_pkg::MIDI_NOTE_OFF || kind == mnrp_pkg::MIDI_NOTE_ON) begin
        if (last_key[m] == key) tone_r[m] = '0;
        onset_tick = onset[m][key];
        if (onset_tick != 16'd0 && key != mnrp_pkg::REPLAY_KEY &&
            key != mnrp_pkg::ZERO_NOTE) begin
          if (n_entries[m] < 9'(DEPTH)) begin
            e.note  = key;
            e.start = onset_tick;
            e.dur   = tick_r[m][7:0] - onset_tick[7:0];
            melody[m][n_entries[m]] = e;
            n_entries[m] = n_entries[m] + 9'd1;
            rec = 1'b1;
          end
          onset[m][key] = '0;
        end
      end
    end
    r.tone_freq  = tone_r[m];
    r.playing    = playing_r[m];
    r.recorded   = rec;
    r.note_count = n_entries[m];
    return r;
  endfunction

  function automatic mnrp_pkg::in_t pack_msg(logic c, logic [7:0] s, logic [6:0] k,
                                             logic [6:0] v);
    mnrp_pkg::in_t it;
    it.cmd         = c;
    it.status_byte = s;
    it.note_number = k;
    it.velocity    = v;
    return it;
  endfunction

  function automatic mnrp_pkg::in_t midi_msg(logic [3:0] kind, logic [6:0] key,
                                             logic [6:0] vel);
    return pack_msg(mnrp_pkg::CMD_MIDI, {kind, 4'($urandom_range(0, 15))}, key, vel);
  endfunction

  function automatic mnrp_pkg::in_t tick_msg();
    return pack_msg(mnrp_pkg::CMD_TICK, 8'($urandom), 7'($urandom), 7'($urandom));
  endfunction

  function automatic mnrp_pkg::in_t noise_msg();
    return pack_msg(mnrp_pkg::CMD_MIDI, 8'($urandom), 7'($urandom), 7'($urandom));
  endfunction

  function automatic mnrp_pkg::in_t off_msg(logic [6:0] key);
    if ($urandom_range(0, 1) == 0)
      return midi_msg(mnrp_pkg::MIDI_NOTE_OFF, key, 7'($urandom));
    return midi_msg(mnrp_pkg::MIDI_NOTE_ON, key, 7'd0);
  endfunction

  function automatic logic [6:0] rand_vel();
    return 7'($urandom_range(1, 127));
  endfunction

  function automatic logic [6:0] free_key();
    logic [6:0] key;
    do key = 7'($urandom);
    while (key == mnrp_pkg::REPLAY_KEY || key == mnrp_pkg::ZERO_NOTE);
    return key;
  endfunction

  function automatic int draw_gap();
    if (no_idle) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic log_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic issue(mnrp_pkg::in_t it);
    logic [3:0] kind;
    kind = it.status_byte[7:4];
    if (it.cmd == mnrp_pkg::CMD_TICK ||
        (!playing_r[PLAN] &&
         (kind == mnrp_pkg::MIDI_NOTE_ON || kind == mnrp_pkg::MIDI_NOTE_OFF)))
      effective_cnt++;
    if (it.cmd == mnrp_pkg::CMD_MIDI && !playing_r[PLAN] &&
        kind == mnrp_pkg::MIDI_NOTE_ON && it.velocity != 7'd0 &&
        it.note_number == mnrp_pkg::REPLAY_KEY)
      play_cnt++;
    void'(recorder_step(PLAN, it));
    issued_cnt++;
    msg_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (done_cnt < issued_cnt) @(posedge clk);
  endtask

  task automatic set_shift(logic [7:0] v);
    wait_idle();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shift_r[CHK]  = v;
    shift_r[PLAN] = v;
    shift_cnt++;
  endtask

  // let any running playback finish, start a new one and tick it through
  task automatic play_out();
    while (playing_r[PLAN]) issue(tick_msg());
    issue(midi_msg(mnrp_pkg::MIDI_NOTE_ON, mnrp_pkg::REPLAY_KEY, rand_vel()));
    while (playing_r[PLAN]) begin
      if ($urandom_range(0, 7) == 0) issue(noise_msg());
      else issue(tick_msg());
    end
  endtask

  always @(posedge clk) begin : driver
    mnrp_pkg::out_t want;
    if (!rst_n) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        want = recorder_step(CHK, in_data);
        status_due.push_back(want);
        if (want.recorded) recorded_cnt++;
      end
      if (!(start && busy)) begin
        if (idle_left != 0) begin
          start     <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (msg_q.size() != 0) begin
          in_data   <= msg_q.pop_front();
          start     <= 1'b1;
          idle_left <= draw_gap();
          if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    mnrp_pkg::out_t want;
    if (rst_n && out_strobe) begin
      done_cnt++;
      if (status_due.size() == 0) begin
        log_failure($sformatf("unexpected result tone %0d playing %0b recorded %0b count %0d",
          out_data.tone_freq, out_data.playing, out_data.recorded, out_data.note_count));
      end else begin
        want = status_due.pop_front();
        if (out_data.tone_freq !== want.tone_freq || out_data.playing !== want.playing ||
            out_data.recorded !== want.recorded || out_data.note_count !== want.note_count)
          log_failure($sformatf({"result %0d: expected tone %0d playing %0b recorded %0b ",
            "count %0d, got tone %0d playing %0b recorded %0b count %0d"}, done_cnt,
            want.tone_freq, want.playing, want.recorded, want.note_count,
            out_data.tone_freq, out_data.playing, out_data.recorded, out_data.note_count));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] shifts [5];
    int         goal;
    int         pick;
    int         extra;
    int         held[$];
    logic [6:0] key;
    model_clear(CHK);
    model_clear(PLAN);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_shift(8'(SHIFT_RESET));

    // directed: field extremes, table edges, ignored commands, zero onset
    issue(pack_msg(mnrp_pkg::CMD_TICK, 8'hFF, 7'h7F, 7'h7F));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h90, mnrp_pkg::REPLAY_KEY, 7'd127));   // empty store
    issue(pack_msg(mnrp_pkg::CMD_TICK, 8'h00, 7'h00, 7'h00));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h90, 7'd60, 7'd1));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h9F, 7'd0, 7'd127));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h95, 7'd127, 7'd64));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h80, 7'd60, 7'h7F));        // not the current note
    issue(tick_msg());
    issue(tick_msg());
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h93, 7'd0, 7'd0));          // velocity zero as off
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h8F, 7'd127, 7'd0));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h91, 7'd33, 7'd90));        // bottom of table
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h92, 7'd81, 7'd90));        // top of table
    issue(tick_msg());
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h82, 7'd81, 7'd0));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'hA0, 7'd20, 7'd20));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'hF0, 7'd33, 7'd1));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h7F, 7'd33, 7'd1));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h80, mnrp_pkg::REPLAY_KEY, 7'd0));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h80, mnrp_pkg::ZERO_NOTE, 7'd0));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h90, mnrp_pkg::ZERO_NOTE, 7'd10));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h90, 7'd62, 7'd10));        // onset at tick zero
    issue(tick_msg());
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h80, 7'd62, 7'd10));
    issue(pack_msg(mnrp_pkg::CMD_MIDI, 8'h80, 7'd33, 7'd10));        // duration wraps
    play_out();

    shifts = '{8'd0, 8'd255, 8'd36, 8'($urandom_range(0, 84)), 8'($urandom)};
    foreach (shifts[i]) begin
      set_shift(shifts[i]);
      if (i == 2) begin
        // fill the store, overrun it, then play it all back
        play_out();
        issue(midi_msg(mnrp_pkg::MIDI_NOTE_ON, mnrp_pkg::ZERO_NOTE, rand_vel()));
        issue(tick_msg());
        extra = 0;
        while (extra < 5) begin
          if (n_entries[PLAN] == 9'(DEPTH)) extra++;
          key = free_key();
          issue(midi_msg(mnrp_pkg::MIDI_NOTE_ON, key, rand_vel()));
          if ($urandom_range(0, 3) == 0) issue(tick_msg());
          issue(off_msg(key));
        end
        play_out();
      end
      goal = effective_cnt + 95;
      issue(midi_msg(mnrp_pkg::MIDI_NOTE_ON, mnrp_pkg::ZERO_NOTE, rand_vel()));
      while (effective_cnt < goal) begin
        if ($urandom_range(0, 59) == 0) wait_idle();
        pick = $urandom_range(0, 99);
        if (playing_r[PLAN]) begin
          if (pick < 12) issue(noise_msg());
          else issue(tick_msg());
        end else if (pick < 30) begin
          key = ($urandom_range(0, 19) == 0) ? 7'($urandom) : free_key();
          issue(midi_msg(mnrp_pkg::MIDI_NOTE_ON, key, rand_vel()));
        end else if (pick < 58) begin
          held.delete();
          for (int n = 0; n < mnrp_pkg::NOTE_SLOTS; n++)
            if (onset[PLAN][n] != 16'd0) held.push_back(n);
          if (held.size() == 0) key = 7'($urandom);
          else key = 7'(held[$urandom_range(0, held.size() - 1)]);
          issue(off_msg(key));
        end else if (pick < 78) begin
          issue(tick_msg());
        end else if (pick < 81) begin
          issue(midi_msg(mnrp_pkg::MIDI_NOTE_ON, mnrp_pkg::ZERO_NOTE, rand_vel()));
        end else if (pick < 83) begin
          issue(midi_msg(mnrp_pkg::MIDI_NOTE_ON, mnrp_pkg::REPLAY_KEY, rand_vel()));
        end else if (pick < 90) begin
          issue(off_msg(7'($urandom)));
        end else begin
          issue(noise_msg());
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (status_due.size() != 0)
      log_failure($sformatf("%0d predicted results never came out", status_due.size()));
    $display("Run: %0d transfers (%0d acting), %0d results checked, %0d pitch shift writes",
      issued_cnt, effective_cnt, done_cnt, shift_cnt);
    $display("Run: %0d notes recorded, %0d playbacks started, %0d mismatches",
      recorded_cnt, play_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
